// File: rtl/dtmt_pkg.sv
`timescale 1ns / 1ps

package dtmt_pkg;

  // Grid geometry
  localparam int TILE_PIXELS = 16;
  localparam int GRID_COLS   = 16;
  localparam int GRID_ROWS   = 8;
  localparam int SPRITE_W    = 8;
  localparam int SPRITE_H    = 8;
  localparam int TILE_COUNT  = GRID_COLS * GRID_ROWS;

  // Field widths
  localparam int OP_W    = 3;
  localparam int COORD_W = 11;
  localparam int IDX_W   = 8;

  // Width for coordinate and index compares: holds 64 * 64 plus sign
  localparam int CMP_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_MOVE     = 3'd0,
    OP_MARK_ALL = 3'd1,
    OP_PLATFORM = 3'd2,
    OP_COIN     = 3'd3,
    OP_EXIT     = 3'd4,
    OP_LOAD     = 3'd5,
    OP_READ     = 3'd6
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the request fields
    logic calc;     // build the tile masks
    logic apply;    // update the flag arrays and load the result
  } ctrl_cmd_t;

endpackage

// File: rtl/dtmt_ctrl.sv
`timescale 1ns / 1ps

module dtmt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dtmt_pkg::ctrl_cmd_t cmd_o
);
  import dtmt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o         = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_APPLY;
      end
      S_APPLY: begin
        // hold until the previous result has been taken
        if (slot_free) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/dtmt_datapath.sv
`timescale 1ns / 1ps

module dtmt_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dtmt_pkg::ctrl_cmd_t                cmd_i,
  input  logic [dtmt_pkg::OP_W-1:0]          op_i,
  input  logic signed [dtmt_pkg::COORD_W-1:0] prev_x_i,
  input  logic signed [dtmt_pkg::COORD_W-1:0] prev_y_i,
  input  logic signed [dtmt_pkg::COORD_W-1:0] cur_x_i,
  input  logic signed [dtmt_pkg::COORD_W-1:0] cur_y_i,
  input  logic [dtmt_pkg::IDX_W-1:0]         tile_index_i,
  input  logic                               flag_value_i,
  output logic                               dirty_bit_o,
  output logic                               index_ok_o
);
  import dtmt_pkg::*;

  // Request fields
  logic [OP_W-1:0]          op_q;
  logic signed [CMP_W-1:0]  px_q, py_q, cx_q, cy_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     flag_q;

  // Masks built in the calc step
  logic [TILE_COUNT-1:0] mark_q, mark_d;
  logic [TILE_COUNT-1:0] hit_q, hit_d;
  logic                  ok_q, ok_d;

  // Flag arrays and result
  logic [TILE_COUNT-1:0] dirty_q, exit_q;
  logic                  dirty_bit_q, index_ok_q;

  logic signed [CMP_W-1:0] pxe, pye, cxe, cye;
  logic [CMP_W-1:0]        idx_w;
  logic [GRID_COLS-1:0]    col_prev, col_cur;
  logic [GRID_ROWS-1:0]    row_prev, row_cur;
  logic [TILE_COUNT-1:0]   foot, plat;

  assign pxe   = px_q + CMP_W'(SPRITE_W - 1);
  assign pye   = py_q + CMP_W'(SPRITE_H - 1);
  assign cxe   = cx_q + CMP_W'(SPRITE_W - 1);
  assign cye   = cy_q + CMP_W'(SPRITE_H - 1);
  assign idx_w = CMP_W'(idx_q);

  // A column lies inside the clamped span when it is not left of the
  // start tile and not right of the end tile; the edge columns absorb
  // everything clamped onto them.
  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    localparam logic signed [CMP_W-1:0] LO = CMP_W'(c * TILE_PIXELS);
    localparam logic signed [CMP_W-1:0] HI = CMP_W'((c + 1) * TILE_PIXELS);
    assign col_prev[c] = ((c == GRID_COLS - 1) || (px_q < HI)) && ((c == 0) || (pxe >= LO));
    assign col_cur[c]  = ((c == GRID_COLS - 1) || (cx_q < HI)) && ((c == 0) || (cxe >= LO));
  end

  for (genvar r = 0; r < GRID_ROWS; r++) begin : g_row
    localparam logic signed [CMP_W-1:0] LO = CMP_W'(r * TILE_PIXELS);
    localparam logic signed [CMP_W-1:0] HI = CMP_W'((r + 1) * TILE_PIXELS);
    assign row_prev[r] = ((r == GRID_ROWS - 1) || (py_q < HI)) && ((r == 0) || (pye >= LO));
    assign row_cur[r]  = ((r == GRID_ROWS - 1) || (cy_q < HI)) && ((r == 0) || (cye >= LO));
  end

  for (genvar i = 0; i < TILE_COUNT; i++) begin : g_tile
    localparam int C = i % GRID_COLS;
    localparam int R = i / GRID_COLS;
    logic left_nb, right_nb;
    assign hit_d[i] = (idx_w == CMP_W'(i));
    assign foot[i]  = (col_prev[C] && row_prev[R]) || (col_cur[C] && row_cur[R]);
    // neighbors only within the same row
    if (C > 0) begin : g_l
      assign left_nb = (idx_w == CMP_W'(i - 1));
    end else begin : g_nl
      assign left_nb = 1'b0;
    end
    if (C < GRID_COLS - 1) begin : g_r
      assign right_nb = (idx_w == CMP_W'(i + 1));
    end else begin : g_nr
      assign right_nb = 1'b0;
    end
    assign plat[i] = hit_d[i] || left_nb || right_nb;
  end

  always_comb begin
    logic in_range;
    in_range = (idx_w < CMP_W'(TILE_COUNT));
    mark_d   = '0;
    ok_d     = 1'b1;
    case (op_q)
      OP_MOVE:     mark_d = foot;
      OP_MARK_ALL: mark_d = '1;
      OP_PLATFORM: mark_d = plat;
      OP_COIN:     mark_d = hit_d;
      OP_EXIT:     mark_d = exit_q;
      default:     mark_d = '0;
    endcase
    if (op_q inside {OP_PLATFORM, OP_COIN, OP_LOAD, OP_READ}) begin
      ok_d = in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      px_q   <= CMP_W'(prev_x_i);
      py_q   <= CMP_W'(prev_y_i);
      cx_q   <= CMP_W'(cur_x_i);
      cy_q   <= CMP_W'(cur_y_i);
      idx_q  <= tile_index_i;
      flag_q <= flag_value_i;
    end
    if (cmd_i.calc) begin
      mark_q <= mark_d;
      hit_q  <= hit_d;
      ok_q   <= ok_d;
    end
    if (cmd_i.apply) begin
      dirty_bit_q <= (op_q == OP_READ) && |(dirty_q & hit_q);
      index_ok_q  <= ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= '0;
      exit_q  <= '0;
    end else if (cmd_i.apply) begin
      case (op_q)
        OP_MOVE:     dirty_q <= mark_q;
        OP_MARK_ALL,
        OP_PLATFORM,
        OP_COIN,
        OP_EXIT:     dirty_q <= dirty_q | mark_q;
        OP_LOAD:     exit_q  <= (exit_q & ~hit_q) | (hit_q & {TILE_COUNT{flag_q}});
        default:     dirty_q <= dirty_q;
      endcase
    end
  end

  assign dirty_bit_o = dirty_bit_q;
  assign index_ok_o  = index_ok_q;

endmodule

// File: rtl/dirty_tile_map_tracker_top.sv
`timescale 1ns / 1ps
// Dirty tile map tracker: one dirty bit and one exit flag per tile of the
// tile grid, both held in flip-flops.
// Request channel: in_valid_i / in_stall_o plus the op and operand fields.
//   A request is taken at a rising edge with in_valid_i high and in_stall_o
//   low. Each request carries one operation (move, mark all, platform, coin,
//   exit, load exit flag, read).
// Result channel: out_valid_o / out_stall_i with dirty_bit_o and index_ok_o.
//   Every request produces exactly one result, in request order.
// Sequencing: each request passes through the three-step controller sequence
//   (capture, mask build, array update); the result is registered at the end
//   of the update step. A new request is taken only once the controller is
//   back in idle, after the previous request has finished its update step.
// Stall: a result waits in the output register while out_stall_i is high;
//   the next request is still taken and brought up to its update step, where
//   it holds until the waiting result has been taken.
// Reset (rst_ni low, asynchronous): both flag arrays clear to zero, the
//   controller returns to idle and no result is pending.
module dirty_tile_map_tracker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [dtmt_pkg::OP_W-1:0]          op_i,
  input  logic signed [dtmt_pkg::COORD_W-1:0] prev_x_i,
  input  logic signed [dtmt_pkg::COORD_W-1:0] prev_y_i,
  input  logic signed [dtmt_pkg::COORD_W-1:0] cur_x_i,
  input  logic signed [dtmt_pkg::COORD_W-1:0] cur_y_i,
  input  logic [dtmt_pkg::IDX_W-1:0]         tile_index_i,
  input  logic                               flag_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               dirty_bit_o,
  output logic                               index_ok_o
);
  import dtmt_pkg::*;

  ctrl_cmd_t cmd;

  // Sequence capture, mask build and update; own the result valid
  dtmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Tile masks, flag arrays and result payload
  dtmt_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (op_i),
    .prev_x_i     (prev_x_i),
    .prev_y_i     (prev_y_i),
    .cur_x_i      (cur_x_i),
    .cur_y_i      (cur_y_i),
    .tile_index_i (tile_index_i),
    .flag_value_i (flag_value_i),
    .dirty_bit_o  (dirty_bit_o),
    .index_ok_o   (index_ok_o)
  );

endmodule
